// ===== design/iexu_pkg.sv =====
package iexu_pkg;

   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_ADDC   = 6'd1;
   localparam logic [5:0] OP_ADDE   = 6'd2;
   localparam logic [5:0] OP_ADDI   = 6'd3;
   localparam logic [5:0] OP_ADDIC  = 6'd4;
   localparam logic [5:0] OP_ADDICR = 6'd5;
   localparam logic [5:0] OP_ADDIS  = 6'd6;
   localparam logic [5:0] OP_ADDME  = 6'd7;
   localparam logic [5:0] OP_ADDZE  = 6'd8;
   localparam logic [5:0] OP_AND    = 6'd9;
   localparam logic [5:0] OP_ANDC   = 6'd10;
   localparam logic [5:0] OP_ANDI   = 6'd11;
   localparam logic [5:0] OP_ANDIS  = 6'd12;
   localparam logic [5:0] OP_CNTLZW = 6'd13;
   localparam logic [5:0] OP_DIVW   = 6'd14;
   localparam logic [5:0] OP_DIVWU  = 6'd15;
   localparam logic [5:0] OP_EXTSB  = 6'd16;
   localparam logic [5:0] OP_EXTSH  = 6'd17;
   localparam logic [5:0] OP_MULHW  = 6'd18;
   localparam logic [5:0] OP_MULHWU = 6'd19;
   localparam logic [5:0] OP_MULLI  = 6'd20;
   localparam logic [5:0] OP_MULLW  = 6'd21;
   localparam logic [5:0] OP_NAND   = 6'd22;
   localparam logic [5:0] OP_NEG    = 6'd23;
   localparam logic [5:0] OP_NOR    = 6'd24;
   localparam logic [5:0] OP_OR     = 6'd25;
   localparam logic [5:0] OP_ORC    = 6'd26;
   localparam logic [5:0] OP_ORI    = 6'd27;
   localparam logic [5:0] OP_ORIS   = 6'd28;
   localparam logic [5:0] OP_RLWIMI = 6'd29;
   localparam logic [5:0] OP_RLWINM = 6'd30;
   localparam logic [5:0] OP_RLWNM  = 6'd31;
   localparam logic [5:0] OP_SRW    = 6'd32;
   localparam logic [5:0] OP_SLW    = 6'd33;
   localparam logic [5:0] OP_SRAW   = 6'd34;
   localparam logic [5:0] OP_SRAWI  = 6'd35;
   localparam logic [5:0] OP_SUBF   = 6'd36;
   localparam logic [5:0] OP_SUBFC  = 6'd37;
   localparam logic [5:0] OP_SUBFE  = 6'd38;
   localparam logic [5:0] OP_SUBFIC = 6'd39;
   localparam logic [5:0] OP_SUBFME = 6'd40;
   localparam logic [5:0] OP_SUBFZE = 6'd41;
   localparam logic [5:0] OP_XOR    = 6'd42;
   localparam logic [5:0] OP_XORI   = 6'd43;
   localparam logic [5:0] OP_XORIS  = 6'd44;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   localparam logic [1:0] UNIT_ALU  = 2'd0;
   localparam logic [1:0] UNIT_MUL  = 2'd1;
   localparam logic [1:0] UNIT_DIV  = 2'd2;
   localparam logic [1:0] UNIT_NONE = 2'd3;

   typedef struct packed {
      logic [5:0]  cmd;
      logic [4:0]  reg_ds;
      logic [4:0]  reg_a;
      logic [4:0]  reg_b;
      logic [15:0] imm16;
      logic [4:0]  mask_begin;
      logic [4:0]  mask_end;
      logic [4:0]  shift_imm;
      logic        oe_bit;
      logic        rc_bit;
   } item_type;

   typedef struct packed {
      item_type   item;
      logic [1:0] unit;
   } entry_type;

   typedef struct packed {
      logic [4:0]  dest_index;
      logic [31:0] result_value;
      logic [3:0]  cr0_flags;
      logic        carry_flag;
      logic        overflow_flag;
      logic        sticky_overflow;
   } result_type;

endpackage

// ===== design/iexu_ram.sv =====
module iexu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/iexu_front.sv =====
module iexu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  iexu_pkg::item_type  item,
   output logic                head_valid,
   output iexu_pkg::entry_type head,
   input  logic                head_pop
);
   import iexu_pkg::*;

   entry_type  entry_ff [2];
   entry_type  entry_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   // Classify by execution unit.
   always_comb begin
      entry_in.item = item;
      if (item.cmd > OP_XORIS) begin
         entry_in.unit = UNIT_NONE;
      end else if (item.cmd == OP_DIVW || item.cmd == OP_DIVWU) begin
         entry_in.unit = UNIT_DIV;
      end else if (item.cmd >= OP_MULHW && item.cmd <= OP_MULLW) begin
         entry_in.unit = UNIT_MUL;
      end else begin
         entry_in.unit = UNIT_ALU;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule

// ===== design/iexu_back.sv =====
module iexu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  iexu_pkg::entry_type  head,
   output logic                 head_pop,
   output logic                 empty,
   input  logic                 pop,
   output iexu_pkg::result_type rsp
);
   import iexu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIX  = 3'd4;
   localparam logic [2:0] S_WB   = 3'd5;

   logic [2:0]  state_ff;
   entry_type   op_ff;
   logic [31:0] vld_ff;
   logic        vld_a_ff, vld_b_ff, vld_s_ff;
   logic [31:0] rd_a, rd_b, rd_s, va, vb, vs;
   logic        carry_ff, ovf_ff, so_ff;
   logic [3:0]  cr0_ff;

   logic [31:0] d_ff;
   logic [4:0]  dest_ff;
   logic        ca_ff, ov_ff, setca_ff, setov_ff, rec_ff, valid_ff;

   logic signed [65:0] prod_ff;
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic [4:0]  cnt_ff;
   logic        neg_ff;

   result_type  q_ff [2];
   logic        qw_ff, qr_ff;
   logic [1:0]  qcnt_ff;
   logic        q_full, q_push, q_pop;

   // Execute stage combinational results.
   logic [31:0] c_d, x, y, simm, uimm, hi_imm, mask, m1, m2, rot, rot_src;
   logic [63:0] rot_wide;
   logic [4:0]  c_dest, rot_n;
   logic        c_ca, c_ov, c_setca, c_setov, c_rec, c_valid, c_add, cin, div_exc;
   logic [32:0] sum;
   logic [5:0]  sh_n, clz;
   logic signed [32:0] mul_a, mul_b;
   logic [31:0] mag_a, mag_b;
   logic [32:0] trial;
   logic        ca_n, ov_n, so_n;
   logic [3:0]  cr_n;
   logic        wb_fire;

   iexu_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
      .clock, .wr_en(wb_fire && valid_ff), .wr_addr(dest_ff), .wr_data(d_ff),
      .rd_addr(head.item.reg_a), .rd_data(rd_a));
   iexu_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
      .clock, .wr_en(wb_fire && valid_ff), .wr_addr(dest_ff), .wr_data(d_ff),
      .rd_addr(head.item.reg_b), .rd_data(rd_b));
   iexu_ram #(.WIDTH(32), .DEPTH(32)) u_ram_s (
      .clock, .wr_en(wb_fire && valid_ff), .wr_addr(dest_ff), .wr_data(d_ff),
      .rd_addr(head.item.reg_ds), .rd_data(rd_s));

   // Never-written registers read as zero.
   assign va = vld_a_ff ? rd_a : 32'd0;
   assign vb = vld_b_ff ? rd_b : 32'd0;
   assign vs = vld_s_ff ? rd_s : 32'd0;

   assign head_pop = (state_ff == S_IDLE) && head_valid;

   assign simm   = {{16{op_ff.item.imm16[15]}}, op_ff.item.imm16};
   assign uimm   = {16'd0, op_ff.item.imm16};
   assign hi_imm = {op_ff.item.imm16, 16'd0};
   assign m1     = 32'hffff_ffff >> op_ff.item.mask_begin;
   assign m2     = 32'hffff_ffff << (5'd31 - op_ff.item.mask_end);
   assign mask   = (op_ff.item.mask_begin <= op_ff.item.mask_end) ? (m1 & m2) : (m1 | m2);
   assign rot_n    = (op_ff.item.cmd == OP_RLWNM) ? vb[4:0] : op_ff.item.shift_imm;
   assign rot_src  = vs;
   assign rot_wide = {rot_src, rot_src} << rot_n;
   assign rot      = rot_wide[63:32];
   assign sh_n     = (op_ff.item.cmd == OP_SRAWI) ? {1'b0, op_ff.item.shift_imm} : vb[5:0];
   assign mag_a    = (op_ff.item.cmd == OP_DIVW && va[31]) ? (32'd0 - va) : va;
   assign mag_b    = (op_ff.item.cmd == OP_DIVW && vb[31]) ? (32'd0 - vb) : vb;
   assign mul_a    = (op_ff.item.cmd == OP_MULHWU) ? $signed({1'b0, va}) : $signed({va[31], va});
   assign mul_b    = (op_ff.item.cmd == OP_MULHWU) ? $signed({1'b0, vb}) :
                     (op_ff.item.cmd == OP_MULLI)  ? $signed({simm[31], simm}) :
                                                     $signed({vb[31], vb});
   assign trial    = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_comb begin
      clz = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (vs[i]) clz = 6'(31 - i);
      end
   end

   always_comb begin
      c_d = 32'd0; c_dest = op_ff.item.reg_a; c_ca = 1'b0; c_ov = 1'b0;
      c_setca = 1'b0; c_setov = 1'b0; c_rec = op_ff.item.rc_bit; c_valid = 1'b1;
      c_add = 1'b0; x = 32'd0; y = 32'd0; cin = 1'b0; div_exc = 1'b0;
      unique case (op_ff.item.cmd)
         OP_ADD, OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE,
         OP_SUBF, OP_SUBFC, OP_SUBFE, OP_SUBFME, OP_SUBFZE: begin
            c_add = 1'b1; c_dest = op_ff.item.reg_ds; c_setov = op_ff.item.oe_bit;
            x = (op_ff.item.cmd >= OP_SUBF) ? ~va : va;
            c_setca = !(op_ff.item.cmd == OP_ADD || op_ff.item.cmd == OP_SUBF);
            if (op_ff.item.cmd == OP_ADDME || op_ff.item.cmd == OP_SUBFME) y = 32'hffff_ffff;
            else if (op_ff.item.cmd == OP_ADDZE || op_ff.item.cmd == OP_SUBFZE) y = 32'd0;
            else y = vb;
            if (op_ff.item.cmd == OP_ADDE || op_ff.item.cmd == OP_ADDME ||
                op_ff.item.cmd == OP_ADDZE || op_ff.item.cmd == OP_SUBFE ||
                op_ff.item.cmd == OP_SUBFME || op_ff.item.cmd == OP_SUBFZE) cin = carry_ff;
            else cin = (op_ff.item.cmd >= OP_SUBF);
         end
         OP_ADDI, OP_ADDIS: begin
            c_add = 1'b1; c_dest = op_ff.item.reg_ds; c_rec = 1'b0;
            x = (op_ff.item.reg_a == 5'd0) ? 32'd0 : va;
            y = (op_ff.item.cmd == OP_ADDIS) ? hi_imm : simm;
         end
         OP_ADDIC, OP_ADDICR, OP_SUBFIC: begin
            c_add = 1'b1; c_dest = op_ff.item.reg_ds; c_setca = 1'b1;
            c_rec = (op_ff.item.cmd == OP_ADDICR);
            x = (op_ff.item.cmd == OP_SUBFIC) ? ~va : va;
            y = simm; cin = (op_ff.item.cmd == OP_SUBFIC);
         end
         OP_AND:    c_d = vs & vb;
         OP_ANDC:   c_d = vs & ~vb;
         OP_ANDI:   begin c_d = vs & uimm; c_rec = 1'b1; end
         OP_ANDIS:  begin c_d = vs & hi_imm; c_rec = 1'b1; end
         OP_CNTLZW: c_d = {26'd0, clz};
         OP_DIVW: begin
            c_dest = op_ff.item.reg_ds; c_setov = op_ff.item.oe_bit;
            div_exc = (vb == 32'd0) || (va == SIGN_BIT && vb == 32'hffff_ffff);
            c_ov = div_exc;
         end
         OP_DIVWU: begin
            c_dest = op_ff.item.reg_ds; c_setov = op_ff.item.oe_bit;
            div_exc = (vb == 32'd0); c_ov = div_exc;
         end
         OP_EXTSB: c_d = {{24{vs[7]}}, vs[7:0]};
         OP_EXTSH: c_d = {{16{vs[15]}}, vs[15:0]};
         OP_MULHW, OP_MULHWU, OP_MULLW: c_dest = op_ff.item.reg_ds;
         OP_MULLI: begin c_dest = op_ff.item.reg_ds; c_rec = 1'b0; end
         OP_NAND: c_d = ~(vs & vb);
         OP_NEG: begin
            c_dest = op_ff.item.reg_ds; c_setov = op_ff.item.oe_bit;
            c_d = 32'd0 - va; c_ov = (va == SIGN_BIT);
         end
         OP_NOR:    c_d = ~(vs | vb);
         OP_OR:     c_d = vs | vb;
         OP_ORC:    c_d = vs | ~vb;
         OP_ORI:    begin c_d = vs | uimm; c_rec = 1'b0; end
         OP_ORIS:   begin c_d = vs | hi_imm; c_rec = 1'b0; end
         OP_RLWIMI: c_d = (rot & mask) | (va & ~mask);
         OP_RLWINM, OP_RLWNM: c_d = rot & mask;
         OP_SRW: c_d = sh_n[5] ? 32'd0 : (vs >> sh_n[4:0]);
         OP_SLW: c_d = sh_n[5] ? 32'd0 : (vs << sh_n[4:0]);
         OP_SRAW, OP_SRAWI: begin
            c_setca = 1'b1;
            if (sh_n[5]) begin
               c_d = {32{vs[31]}}; c_ca = vs[31];
            end else begin
               c_d  = 32'($signed(vs) >>> sh_n[4:0]);
               c_ca = vs[31] && ((vs & ~(32'hffff_ffff << sh_n[4:0])) != 32'd0);
            end
         end
         OP_XOR:  c_d = vs ^ vb;
         OP_XORI: begin c_d = vs ^ uimm; c_rec = 1'b0; end
         OP_XORIS: begin c_d = vs ^ hi_imm; c_rec = 1'b0; end
         default: begin
            c_valid = 1'b0; c_rec = 1'b0; c_dest = 5'd0;
         end
      endcase
      sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      if (c_add) begin
         c_d  = sum[31:0];
         c_ca = sum[32];
         c_ov = ((x ^ sum[31:0]) & (y ^ sum[31:0]) & SIGN_BIT) != 32'd0;
      end
   end

   // Architectural flag update at writeback.
   always_comb begin
      ca_n = setca_ff ? ca_ff : carry_ff;
      ov_n = setov_ff ? ov_ff : ovf_ff;
      so_n = so_ff | (setov_ff & ov_ff);
      if (rec_ff) begin
         if (d_ff == 32'd0)  cr_n = {3'b001, so_n};
         else if (d_ff[31]) cr_n = {3'b100, so_n};
         else                cr_n = {3'b010, so_n};
      end else begin
         cr_n = cr0_ff;
      end
   end

   assign q_full  = (qcnt_ff == 2'd2);
   assign wb_fire = (state_ff == S_WB) && !q_full;
   assign q_push  = wb_fire;
   assign empty   = (qcnt_ff == 2'd0);
   assign q_pop   = pop && !empty;
   assign rsp     = q_ff[qr_ff];

   always_ff @(posedge clock) begin
      if (head_pop) begin
         op_ff    <= head;
         vld_a_ff <= vld_ff[head.item.reg_a];
         vld_b_ff <= vld_ff[head.item.reg_b];
         vld_s_ff <= vld_ff[head.item.reg_ds];
      end
      if (state_ff == S_EXEC) begin
         d_ff <= c_d; dest_ff <= c_dest; ca_ff <= c_ca; ov_ff <= c_ov;
         setca_ff <= c_setca; setov_ff <= c_setov; rec_ff <= c_rec; valid_ff <= c_valid;
         prod_ff  <= mul_a * mul_b;
         quo_ff   <= mag_a; dvs_ff <= mag_b; rem_ff <= 32'd0;
         neg_ff   <= (op_ff.item.cmd == OP_DIVW) && (va[31] ^ vb[31]);
      end
      if (state_ff == S_MUL) begin
         d_ff <= (op_ff.item.cmd == OP_MULHW || op_ff.item.cmd == OP_MULHWU) ?
                 prod_ff[63:32] : prod_ff[31:0];
      end
      if (state_ff == S_DIV) begin
         // One restoring step per cycle.
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (state_ff == S_FIX) begin
         d_ff <= neg_ff ? (32'd0 - quo_ff) : quo_ff;
      end
      if (q_push) begin
         q_ff[qw_ff] <= '{dest_index: dest_ff, result_value: d_ff, cr0_flags: cr_n,
                          carry_flag: ca_n, overflow_flag: ov_n, sticky_overflow: so_n};
      end
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 32'd0;
         carry_ff <= 1'b0; ovf_ff <= 1'b0; so_ff <= 1'b0; cr0_ff <= 4'd0;
         cnt_ff   <= 5'd0;
         qw_ff    <= 1'b0; qr_ff <= 1'b0; qcnt_ff <= 2'd0;
      end else begin
         if (q_push) qw_ff <= !qw_ff;
         if (q_pop)  qr_ff <= !qr_ff;
         qcnt_ff <= qcnt_ff + {1'b0, q_push} - {1'b0, q_pop};
         unique case (state_ff)
            S_IDLE: if (head_valid) state_ff <= S_EXEC;
            S_EXEC: begin
               cnt_ff <= 5'd0;
               if (op_ff.unit == UNIT_MUL) state_ff <= S_MUL;
               else if (op_ff.unit == UNIT_DIV && !div_exc) state_ff <= S_DIV;
               else state_ff <= S_WB;
            end
            S_MUL: state_ff <= S_WB;
            S_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) state_ff <= S_FIX;
            end
            S_FIX: state_ff <= S_WB;
            S_WB: begin
               if (wb_fire) begin
                  if (valid_ff) begin
                     vld_ff[dest_ff] <= 1'b1;
                     carry_ff <= ca_n; ovf_ff <= ov_n; so_ff <= so_n; cr0_ff <= cr_n;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== design/powerpc_integer_execute_unit.sv =====
// Channel    Handshake           Payload
// request    push / full         req_cmd .. req_rc_bit (decoded instruction)
// response   pop / empty         rsp_dest_index .. rsp_sticky_overflow
//
// Each instruction passes read, execute and write back in the back end;
// multiplies add a product register step; divides add a restoring loop, one
// quotient bit per cycle, and a sign fix, skipped on a zero divisor or signed overflow.
// Reset clears the register file valid bits, XER and CR0 at once; no sweep.
// A two-entry request queue lets the front keep taking transfers while the
// back works; a two-entry result queue holds results while pop is low, and
// write back holds while that queue is full.
module powerpc_integer_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [5:0]  req_cmd,
   input  logic [4:0]  req_reg_ds,
   input  logic [4:0]  req_reg_a,
   input  logic [4:0]  req_reg_b,
   input  logic [15:0] req_imm16,
   input  logic [4:0]  req_mask_begin,
   input  logic [4:0]  req_mask_end,
   input  logic [4:0]  req_shift_imm,
   input  logic        req_oe_bit,
   input  logic        req_rc_bit,
   output logic        empty,
   input  logic        pop,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_result_value,
   output logic [3:0]  rsp_cr0_flags,
   output logic        rsp_carry_flag,
   output logic        rsp_overflow_flag,
   output logic        rsp_sticky_overflow
);
   import iexu_pkg::*;

   item_type   req_item;
   entry_type  head;
   logic       head_valid, head_pop;
   result_type rsp;

   // Bundle the request fields for the front queue.
   assign req_item = '{cmd: req_cmd, reg_ds: req_reg_ds, reg_a: req_reg_a,
                       reg_b: req_reg_b, imm16: req_imm16, mask_begin: req_mask_begin,
                       mask_end: req_mask_end, shift_imm: req_shift_imm,
                       oe_bit: req_oe_bit, rc_bit: req_rc_bit};

   iexu_front u_front (
      .clock, .reset, .push, .full, .item(req_item),
      .head_valid, .head, .head_pop);

   iexu_back u_back (
      .clock, .reset, .head_valid, .head, .head_pop,
      .empty, .pop, .rsp);

   // Drive the oldest result onto the response ports.
   assign rsp_dest_index      = rsp.dest_index;
   assign rsp_result_value    = rsp.result_value;
   assign rsp_cr0_flags       = rsp.cr0_flags;
   assign rsp_carry_flag      = rsp.carry_flag;
   assign rsp_overflow_flag   = rsp.overflow_flag;
   assign rsp_sticky_overflow = rsp.sticky_overflow;
endmodule

// ===== tb/testbench.sv =====
module testbench;
   import iexu_pkg::*;

   // Scoreboard: mirrors the architected state and queues predicted results.
   class alu_scoreboard;
      logic [31:0] gpr[32];
      logic        xer_ca, xer_ov, xer_so;
      logic [3:0]  cr0;
      result_type  pending[$];
      int          errors;

      function void clear();
         for (int i = 0; i < 32; i++) gpr[i] = '0;
         xer_ca = 0; xer_ov = 0; xer_so = 0; cr0 = '0;
         errors = 0;
      endfunction

      function logic [31:0] rotl(logic [31:0] v, logic [4:0] n);
         return (n == 0) ? v : ((v << n) | (v >> (6'd32 - n)));
      endfunction

      function logic [31:0] mask(logic [4:0] mb, logic [4:0] me);
         logic [31:0] m1, m2;
         m1 = 32'hffff_ffff >> mb;
         m2 = 32'hffff_ffff << (5'd31 - me);
         return (mb <= me) ? (m1 & m2) : (m1 | m2);
      endfunction

      // Execute one instruction on the shadow state, queue the result.
      function void note_issue(item_type it);
         logic [31:0] va, vb, vs, simm, zimm, d, x, y, ma, mbv, m;
         logic [32:0] sum;
         logic [63:0] p;
         logic [5:0]  n;
         logic [4:0]  dest;
         logic        ca, ov, cin, valid, is_add, setca, setov, rec;
         result_type  r;
         va = gpr[it.reg_a]; vb = gpr[it.reg_b]; vs = gpr[it.reg_ds];
         simm = {{16{it.imm16[15]}}, it.imm16};
         zimm = {16'h0, it.imm16};
         d = 0; dest = it.reg_a; ca = 0; ov = 0; x = 0; y = 0; cin = 0;
         valid = 1; is_add = 0; setca = 0; setov = 0; rec = it.rc_bit;
         case (it.cmd)
            OP_ADD, OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE,
            OP_SUBF, OP_SUBFC, OP_SUBFE, OP_SUBFME, OP_SUBFZE: begin
               is_add = 1; dest = it.reg_ds; setov = it.oe_bit;
               x = (it.cmd >= OP_SUBF) ? ~va : va;
               setca = !(it.cmd == OP_ADD || it.cmd == OP_SUBF);
               if (it.cmd == OP_ADDME || it.cmd == OP_SUBFME) y = '1;
               else if (it.cmd == OP_ADDZE || it.cmd == OP_SUBFZE) y = 0;
               else y = vb;
               if (it.cmd inside {OP_ADDE, OP_ADDME, OP_ADDZE, OP_SUBFE, OP_SUBFME,
                                  OP_SUBFZE})
                  cin = xer_ca;
               else cin = (it.cmd >= OP_SUBF);
            end
            OP_ADDI, OP_ADDIS: begin
               is_add = 1; dest = it.reg_ds; rec = 0;
               x = (it.reg_a == 0) ? 0 : va;
               y = (it.cmd == OP_ADDIS) ? {it.imm16, 16'h0} : simm;
            end
            OP_ADDIC, OP_ADDICR, OP_SUBFIC: begin
               is_add = 1; dest = it.reg_ds; setca = 1; rec = (it.cmd == OP_ADDICR);
               x = (it.cmd == OP_SUBFIC) ? ~va : va;
               y = simm; cin = (it.cmd == OP_SUBFIC);
            end
            OP_AND:   d = vs & vb;
            OP_ANDC:  d = vs & ~vb;
            OP_ANDI:  begin d = vs & zimm; rec = 1; end
            OP_ANDIS: begin d = vs & {it.imm16, 16'h0}; rec = 1; end
            OP_CNTLZW: begin
               d = 32;
               for (int i = 0; i < 32; i++) if (vs[i]) d = 31 - i;
            end
            OP_DIVW: begin
               dest = it.reg_ds; setov = it.oe_bit;
               if (vb == 0 || (va == SIGN_BIT && vb == '1)) begin
                  d = 0; ov = 1;
               end else begin
                  ma = va[31] ? -va : va;
                  mbv = vb[31] ? -vb : vb;
                  d = ma / mbv;
                  if (va[31] ^ vb[31]) d = -d;
               end
            end
            OP_DIVWU: begin
               dest = it.reg_ds; setov = it.oe_bit;
               if (vb == 0) begin d = 0; ov = 1; end
               else d = va / vb;
            end
            OP_EXTSB: d = {{24{vs[7]}}, vs[7:0]};
            OP_EXTSH: d = {{16{vs[15]}}, vs[15:0]};
            OP_MULHW, OP_MULLI, OP_MULLW: begin
               p = $signed({{32{va[31]}}, va}) *
                   $signed(it.cmd == OP_MULLI ? {{32{simm[31]}}, simm}
                                              : {{32{vb[31]}}, vb});
               dest = it.reg_ds;
               d = (it.cmd == OP_MULHW) ? p[63:32] : p[31:0];
               if (it.cmd == OP_MULLI) rec = 0;
            end
            OP_MULHWU: begin
               p = {32'h0, va} * {32'h0, vb};
               dest = it.reg_ds; d = p[63:32];
            end
            OP_NAND: d = ~(vs & vb);
            OP_NEG: begin
               dest = it.reg_ds; setov = it.oe_bit;
               d = -va; ov = (va == SIGN_BIT);
            end
            OP_NOR:  d = ~(vs | vb);
            OP_OR:   d = vs | vb;
            OP_ORC:  d = vs | ~vb;
            OP_ORI:  begin d = vs | zimm; rec = 0; end
            OP_ORIS: begin d = vs | {it.imm16, 16'h0}; rec = 0; end
            OP_RLWIMI: begin
               m = mask(it.mask_begin, it.mask_end);
               d = (rotl(vs, it.shift_imm) & m) | (va & ~m);
            end
            OP_RLWINM: d = rotl(vs, it.shift_imm) & mask(it.mask_begin, it.mask_end);
            OP_RLWNM:  d = rotl(vs, vb[4:0]) & mask(it.mask_begin, it.mask_end);
            OP_SRW, OP_SLW: begin
               n = vb[5:0];
               if (n[5]) d = 0;
               else d = (it.cmd == OP_SRW) ? (vs >> n) : (vs << n);
            end
            OP_SRAW, OP_SRAWI: begin
               setca = 1;
               n = (it.cmd == OP_SRAW) ? vb[5:0] : {1'b0, it.shift_imm};
               if (n[5]) begin
                  d = {32{vs[31]}}; ca = vs[31];
               end else begin
                  d = $signed(vs) >>> n;
                  ca = vs[31] && n != 0 && ((vs & ((32'h1 << n) - 1)) != 0);
               end
            end
            OP_XOR:   d = vs ^ vb;
            OP_XORI:  begin d = vs ^ zimm; rec = 0; end
            OP_XORIS: begin d = vs ^ {it.imm16, 16'h0}; rec = 0; end
            default: begin valid = 0; rec = 0; dest = 0; d = 0; end
         endcase
         if (is_add) begin
            sum = {1'b0, x} + {1'b0, y} + cin;
            d = sum[31:0]; ca = sum[32];
            ov = (x[31] ^ d[31]) & (y[31] ^ d[31]);
         end
         if (valid) begin
            gpr[dest] = d;
            if (setca) xer_ca = ca;
            if (setov) begin xer_ov = ov; xer_so = xer_so | ov; end
            // OV/SO first, so a recorded CR0 carries the new SO
            if (rec) cr0 = ((d == 0) ? 4'd2 : d[31] ? 4'd8 : 4'd4) | {3'b0, xer_so};
         end
         r.dest_index = dest; r.result_value = d; r.cr0_flags = cr0;
         r.carry_flag = xer_ca; r.overflow_flag = xer_ov; r.sticky_overflow = xer_so;
         pending.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: dest %0d value %h",
                   got.dest_index, got.result_value);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.dest_index !== e.dest_index) begin
            $error("dest_index expected %0d got %0d", e.dest_index, got.dest_index);
            errors++;
         end
         if (got.result_value !== e.result_value) begin
            $error("result_value expected %h got %h", e.result_value, got.result_value);
            errors++;
         end
         if (got.cr0_flags !== e.cr0_flags) begin
            $error("cr0_flags expected %h got %h", e.cr0_flags, got.cr0_flags);
            errors++;
         end
         if (got.carry_flag !== e.carry_flag) begin
            $error("carry_flag expected %b got %b", e.carry_flag, got.carry_flag);
            errors++;
         end
         if (got.overflow_flag !== e.overflow_flag) begin
            $error("overflow_flag expected %b got %b", e.overflow_flag, got.overflow_flag);
            errors++;
         end
         if (got.sticky_overflow !== e.sticky_overflow) begin
            $error("sticky_overflow expected %b got %b",
                   e.sticky_overflow, got.sticky_overflow);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        pop = 0;
   logic        full, empty;
   item_type    req = '0;
   result_type  rsp;
   logic        drain_hold = 0;  // receiver long hold-off request
   bit          stim_done = 0;

   alu_scoreboard sb = new();

   always #5 clock = ~clock;

   powerpc_integer_execute_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_cmd(req.cmd), .req_reg_ds(req.reg_ds), .req_reg_a(req.reg_a),
      .req_reg_b(req.reg_b), .req_imm16(req.imm16), .req_mask_begin(req.mask_begin),
      .req_mask_end(req.mask_end), .req_shift_imm(req.shift_imm),
      .req_oe_bit(req.oe_bit), .req_rc_bit(req.rc_bit),
      .empty(empty), .pop(pop),
      .rsp_dest_index(rsp.dest_index), .rsp_result_value(rsp.result_value),
      .rsp_cr0_flags(rsp.cr0_flags), .rsp_carry_flag(rsp.carry_flag),
      .rsp_overflow_flag(rsp.overflow_flag), .rsp_sticky_overflow(rsp.sticky_overflow)
   );

   // Sample both handshakes at the rising edge; predict on each request transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_issue(req);
         if (pop && !empty) sb.check_result(rsp);
      end
   end

   // Present one instruction and hold it until the transfer happens.
   task automatic issue(item_type it);
      @(negedge clock);
      req <= it;
      push <= 1;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic idle(int cycles);
      @(negedge clock);
      push <= 0;
      repeat (cycles) @(negedge clock);
   endtask

   // Random instruction; operand values are steered to corner values now and then
   // by loading registers with extremes through the directed part and addis/ori.
   function automatic item_type rand_item();
      item_type it;
      it.cmd        = ($urandom_range(0, 30) == 0) ? 6'($urandom_range(45, 63))
                                                   : 6'($urandom_range(0, 44));
      it.reg_ds     = 5'($urandom);
      it.reg_a      = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom);
      it.reg_b      = 5'($urandom);
      case ($urandom_range(0, 5))
         0: it.imm16 = 16'h0000;
         1: it.imm16 = 16'hffff;
         2: it.imm16 = 16'h8000;
         3: it.imm16 = 16'h7fff;
         default: it.imm16 = 16'($urandom);
      endcase
      it.mask_begin = 5'($urandom);
      it.mask_end   = 5'($urandom);
      it.shift_imm  = 5'($urandom);
      it.oe_bit     = 1'($urandom);
      it.rc_bit     = 1'($urandom);
      // keep divides rare, they hold the back end in its restoring loop
      if ((it.cmd == OP_DIVW || it.cmd == OP_DIVWU) && $urandom_range(0, 2) != 0)
         it.cmd = OP_ADD;
      return it;
   endfunction

   function automatic item_type mk(logic [5:0] c, logic [4:0] ds, logic [4:0] a,
                                   logic [4:0] b, logic [15:0] imm);
      item_type it;
      it = '0;
      it.cmd = c; it.reg_ds = ds; it.reg_a = a; it.reg_b = b; it.imm16 = imm;
      it.oe_bit = 1; it.rc_bit = 1;
      return it;
   endfunction

   // Receiver: stall on its own pattern, with one long hold-off on request.
   initial begin
      int phase;
      bit held;
      phase = 0;
      held = 0;
      @(negedge clock);
      while (1) begin
         @(negedge clock);
         phase++;
         if (drain_hold && !held) begin
            // hold off for a long stretch while the sender keeps offering
            held = 1;
            pop <= 0;
            repeat (200) @(negedge clock);
         end else if ((phase / 64) % 3 == 0) pop <= 1;  // stretch with no stalls
         else pop <= ($urandom_range(0, 3) != 0);
      end
   end

   // Sender.
   initial begin
      item_type it;
      bit paused;
      paused = 0;
      sb.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: load extremes, then the special cases.
      issue(mk(OP_ADDIS, 5'd1, 5'd0, 5'd0, 16'h8000));  // r1 = 0x80000000
      issue(mk(OP_ADDI,  5'd2, 5'd0, 5'd0, 16'hffff));  // r2 = -1
      issue(mk(OP_ADDIS, 5'd3, 5'd0, 5'd0, 16'h7fff));
      issue(mk(OP_ORI,   5'd3, 5'd3, 5'd0, 16'hffff));  // ori writes rA: r3 = max
      issue(mk(OP_DIVW,  5'd4, 5'd1, 5'd2, 16'h0));     // min / -1
      issue(mk(OP_DIVWU, 5'd5, 5'd3, 5'd0, 16'h0));     // divide by zero
      issue(mk(OP_ADD,   5'd6, 5'd3, 5'd3, 16'h0));     // signed overflow
      issue(mk(OP_ADDC,  5'd7, 5'd2, 5'd2, 16'h0));     // carry out
      issue(mk(OP_ADDE,  5'd8, 5'd0, 5'd0, 16'h0));
      issue(mk(OP_NEG,   5'd9, 5'd1, 5'd0, 16'h0));
      issue(mk(OP_MULHW, 5'd10, 5'd1, 5'd1, 16'h0));    // OE ignored
      issue(mk(OP_MULHWU,5'd11, 5'd2, 5'd2, 16'h0));
      issue(mk(OP_ADDICR,5'd12, 5'd2, 5'd0, 16'h0001));
      issue(mk(OP_ANDI,  5'd2, 5'd13, 5'd0, 16'h8000));
      issue(mk(OP_XORIS, 5'd2, 5'd14, 5'd0, 16'hffff));
      it = mk(OP_SRAW, 5'd1, 5'd15, 5'd0, 16'h0);        // sraw by 0
      issue(it);
      issue(mk(OP_ADDI,  5'd16, 5'd0, 5'd0, 16'h0020));  // r16 = 32
      issue(mk(OP_SRAW,  5'd1, 5'd17, 5'd16, 16'h0));    // amount 32
      issue(mk(OP_SLW,   5'd2, 5'd18, 5'd16, 16'h0));
      issue(mk(OP_SRW,   5'd2, 5'd19, 5'd16, 16'h0));
      it = mk(OP_SRAWI, 5'd1, 5'd20, 5'd0, 16'h0); it.shift_imm = 5'd31;
      issue(it);
      it = mk(OP_RLWINM, 5'd2, 5'd21, 5'd0, 16'h0);
      it.mask_begin = 5'd31; it.mask_end = 5'd0; it.shift_imm = 5'd31;
      issue(it);
      issue(mk(OP_CNTLZW, 5'd0, 5'd22, 5'd0, 16'h0));
      issue(mk(6'd63, 5'd31, 5'd31, 5'd31, 16'hffff));  // unused opcode
      issue(mk(OP_EXTSH, 5'd1, 5'd23, 5'd0, 16'h0));

      // Random part in bursts with gaps.
      for (int i = 0; i < 1700; ) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && i < 1700; k++, i++) begin
            issue(rand_item());
            // long receiver hold-off while the sender keeps going
            if (i == 400) drain_hold = 1;
         end
         if (!paused && i >= 900) begin
            // pause until every predicted result has come back
            paused = 1;
            idle(0);
            while (sb.pending.size() != 0) @(negedge clock);
         end
         else idle($urandom_range(0, 6));
      end
      @(negedge clock);
      push <= 0;
      stim_done = 1;
   end

   // End of run.
   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[powerpc_integer_execute_unit] OK");
      else
         $display("[powerpc_integer_execute_unit] ERROR");
      $finish;
   end

   // Watchdog, well above the slowest legal run.
   initial begin
      #3000000;
      $display("[powerpc_integer_execute_unit] ERROR");
      $finish;
   end
endmodule

// ===== powerpc_integer_execute_unit.f =====
design/iexu_pkg.sv
design/iexu_ram.sv
design/iexu_front.sv
design/iexu_back.sv
design/powerpc_integer_execute_unit.sv
tb/testbench.sv
